FILE: rtl/kmacd_pkg.sv
`default_nettype none

package kmacd_pkg;

  // Filter geometry. AVG_DEPTH is a power of two so the average is a shift.
  localparam int KNOBS      = 2;
  localparam int AVG_DEPTH  = 64;
  localparam int AVG_SHIFT  = $clog2(AVG_DEPTH);
  localparam int RING_DEPTH = KNOBS * AVG_DEPTH;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int KNOB_W     = (KNOBS > 1) ? $clog2(KNOBS) : 1;

  localparam int SAMPLE_W = 8;
  localparam int CHAN_W   = 4;
  localparam int CTRL_W   = 7;
  localparam int LEVEL_W  = 7;
  localparam int SUM_W    = SAMPLE_W + AVG_SHIFT;

  // Result queue between the filter and the output port.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CTRL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_CTRL = 2'd1;

  localparam logic [CTRL_W-1:0] FIRST_CTRL_RESET  = 7'd20;
  localparam logic [CTRL_W-1:0] SECOND_CTRL_RESET = 7'd21;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]   midi_channel;
  } kmacd_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  out_channel;
    logic [CTRL_W-1:0]  controller;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } kmacd_out_t;

  typedef struct packed {
    logic [CTRL_W-1:0] first_ctrl;
    logic [CTRL_W-1:0] second_ctrl;
  } kmacd_cfg_t;

  // One queued report. A warm-up entry carries the levels of every knob and
  // expands into KNOBS beats; a normal entry reports levels[knob] only.
  typedef struct packed {
    logic [CHAN_W-1:0]               chan;
    logic                            warm;
    logic [KNOB_W-1:0]               knob;
    logic [KNOBS-1:0][LEVEL_W-1:0]   levels;
  } kmacd_entry_t;

  typedef struct packed {
    logic         valid;
    kmacd_entry_t entry;
  } kmacd_push_t;

  function automatic logic [LEVEL_W-1:0] level_of(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] shifted;
    shifted = s >> (AVG_SHIFT + 1);
    return shifted[LEVEL_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/kmacd_ram.sv
`default_nettype none

module kmacd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/kmacd_filter.sv
`default_nettype none

module kmacd_filter
  import kmacd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  input  wire kmacd_in_t   item,
  output logic             item_stall,
  input  wire logic        q_full,
  output kmacd_push_t      push
);

  logic [ADDR_W-1:0] count;
  logic [KNOB_W-1:0] knob;

  logic              a_valid;
  kmacd_in_t         a_item;
  logic [ADDR_W-1:0] a_addr;
  logic [KNOB_W-1:0] a_knob;

  logic                      warmed;
  logic [SUM_W-1:0]          sums      [KNOBS];
  logic [LEVEL_W-1:0]        last_sent [KNOBS];

  logic                          accept;
  logic                          b_fire;
  logic [SAMPLE_W-1:0]           ram_q;
  logic [SAMPLE_W-1:0]           old_sample;
  logic [SUM_W-1:0]              sum_next;
  logic [LEVEL_W-1:0]            lvl_new;
  logic                          warm_now;
  logic                          changed;
  logic [KNOBS-1:0][LEVEL_W-1:0] levels;

  assign item_stall = a_valid && q_full;
  assign accept     = item_valid && !item_stall;
  assign b_fire     = a_valid && !q_full;

  kmacd_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (b_fire),
    .waddr(a_addr),
    .wdata(a_item.sample),
    .re   (accept),
    .raddr(count),
    .rdata(ram_q)
  );

  // Before the first full pass every slot is treated as zero; the ring itself is never reset.
  always_comb begin
    old_sample = warmed ? ram_q : '0;
    sum_next   = sums[a_knob] - SUM_W'(old_sample) + SUM_W'(a_item.sample);
    lvl_new    = level_of(sum_next);
    warm_now   = !warmed && (a_addr == ADDR_W'(RING_DEPTH - 1));
    changed    = lvl_new != last_sent[a_knob];
    for (int k = 0; k < KNOBS; k++) begin
      levels[k] = (KNOB_W'(k) == a_knob) ? lvl_new : level_of(sums[k]);
    end
    push.valid        = b_fire && (warm_now || (warmed && changed));
    push.entry.chan   = a_item.midi_channel;
    push.entry.warm   = warm_now;
    push.entry.knob   = a_knob;
    push.entry.levels = levels;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      knob    <= '0;
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
      count   <= (count == ADDR_W'(RING_DEPTH - 1)) ? '0 : count + 1'b1;
      knob    <= (knob == KNOB_W'(KNOBS - 1)) ? '0 : knob + 1'b1;
    end else if (b_fire) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_item <= item;
      a_addr <= count;
      a_knob <= knob;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      warmed <= 1'b0;
      for (int k = 0; k < KNOBS; k++) begin
        sums[k]      <= '0;
        last_sent[k] <= '0;
      end
    end else if (b_fire) begin
      sums[a_knob] <= sum_next;
      if (warm_now) begin
        warmed <= 1'b1;
        for (int k = 0; k < KNOBS; k++) begin
          last_sent[k] <= levels[k];
        end
      end else if (warmed) begin
        last_sent[a_knob] <= lvl_new;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/kmacd_outq.sv
`default_nettype none

module kmacd_outq
  import kmacd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire kmacd_push_t push,
  input  wire kmacd_cfg_t  cfg,
  output logic             q_full,
  output logic             result_valid,
  output kmacd_out_t       result,
  input  wire logic        result_stall
);

  kmacd_entry_t        entries [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr;
  logic [OQ_PTR_W-1:0] rd_ptr;
  logic [OQ_CNT_W-1:0] fill;
  logic [KNOB_W-1:0]   burst_k;

  kmacd_entry_t      head;
  logic [KNOB_W-1:0] sel;
  logic              last_beat;
  logic              out_fire;
  logic              pop;
  logic              do_push;

  assign q_full       = fill == OQ_CNT_W'(OQ_DEPTH);
  assign result_valid = fill != '0;
  assign out_fire     = result_valid && !result_stall;
  assign pop          = out_fire && last_beat;
  assign do_push      = push.valid && !q_full;

  always_comb begin
    head      = entries[rd_ptr];
    sel       = head.warm ? burst_k : head.knob;
    last_beat = !head.warm || (burst_k == KNOB_W'(KNOBS - 1));
    result.out_channel = head.chan;
    result.level       = head.levels[sel];
    result.last        = last_beat;
    if (sel == '0) begin
      result.controller = cfg.first_ctrl;
    end else begin
      result.controller = cfg.second_ctrl + CTRL_W'(sel) - CTRL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      fill    <= '0;
      burst_k <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr  <= rd_ptr + 1'b1;
        burst_k <= '0;
      end else if (out_fire) begin
        burst_k <= burst_k + 1'b1;
      end
      fill <= fill + OQ_CNT_W'(do_push) - OQ_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/knob_moving_average_change_detect_core.sv
`default_nettype none

// Channel   Handshake           Payload                      Direction
// item      item_valid/stall    kmacd_in_t  (sample, chan)   into the block
// result    result_valid/stall  kmacd_out_t (report beat)    out of the block
// cfg       cfg_valid/ready     cfg_index, cfg_data          into the block
//
// One sample beat is taken per cycle unless item_stall is high. A sample
// reads its ring slot in the cycle it is taken and updates the running sum,
// the ring and the change state from stage a once the queue has room. After
// the synchronous reset the ring is treated as zero until the first full
// pass, so no clearing sweep is needed. item_stall rises only while the
// four-entry result queue is full and a sample is waiting.

module knob_moving_average_change_detect_core
  import kmacd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  input  wire kmacd_in_t            item,
  output logic                      item_stall,
  output logic                      result_valid,
  output kmacd_out_t                result,
  input  wire logic                 result_stall,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CTRL_W-1:0]    cfg_data
);

  kmacd_cfg_t  cfg;
  kmacd_push_t push;
  logic        q_full;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_ctrl  <= FIRST_CTRL_RESET;
      cfg.second_ctrl <= SECOND_CTRL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FIRST_CTRL: begin
          cfg.first_ctrl <= cfg_data;
        end
        CFG_SECOND_CTRL: begin
          cfg.second_ctrl <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // The filter owns the ring memory, the per-knob sums and the last level
  // reported for each knob; it pushes at most one report entry per sample.
  kmacd_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item      (item),
    .item_stall(item_stall),
    .q_full    (q_full),
    .push      (push)
  );

  // The queue decouples the sample side from the result side and expands the
  // warm-up report into one beat per knob, marking only the final one.
  kmacd_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .cfg         (cfg),
    .q_full      (q_full),
    .result_valid(result_valid),
    .result      (result),
    .result_stall(result_stall)
  );

endmodule

`default_nettype wire
